>>> rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/bma_pkg.sv
// Types, constants and command codes of the bitmap allocator core.
package bma_pkg;

   localparam int unsigned MAX_BITS   = 4096;
   localparam int unsigned WORD_BITS  = 64;
   localparam int unsigned WORD_SHIFT = 6;
   localparam int unsigned MAP_WORDS  = MAX_BITS / WORD_BITS;
   localparam int unsigned ADDR_W     = $clog2(MAP_WORDS);
   localparam int unsigned PTR_W      = ADDR_W + 1;
   localparam int unsigned INDEX_W    = 12;
   localparam int unsigned COUNT_W    = 13;
   localparam int unsigned CMD_W      = 3;

   localparam logic [COUNT_W-1:0]   COUNT_LIMIT = '1;
   localparam logic [COUNT_W-1:0]   BITS_MAX    = COUNT_W'(MAX_BITS);
   localparam logic [COUNT_W-1:0]   BITS_RESET  = COUNT_W'(MAX_BITS);
   localparam logic [WORD_BITS-1:0] FULL_WORD   = '1;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_MARK   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UNMARK = 3'd2;
   localparam logic [CMD_W-1:0] CMD_FLIP   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd5;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [INDEX_W-1:0] bit_sel;
   } bma_req_type;

   typedef struct packed {
      logic               bit_state;
      logic               found;
      logic [INDEX_W-1:0] found_index;
      logic [COUNT_W-1:0] marked_count;
      logic               all_marked;
      logic               all_unmarked;
      logic               ignored;
   } bma_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } bma_state_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free;
      logic is_clear;
      logic is_bitop;
      logic is_find;
      logic in_range;
      logic mark_walk;
      logic ptr_lt_nw;
      logic word_hit;
      logic word_full;
   } bma_stat_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic do_clear;
      logic do_bit;
      logic ptr_inc;
      logic hint_ptr;
      logic hint_nw;
      logic emit;
      logic ign;
      logic fnd;
   } bma_ctl_type;

endpackage

>>> rtl/core/bma_ctrl.sv
// Sequencing state machine of the bitmap allocator core.
module bma_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bma_pkg::bma_stat_type stat,
   output bma_pkg::bma_ctl_type  ctl
);
   import bma_pkg::*;

   bma_state_type state_ff, state_in;
   logic          scan_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_stall = 1'b1;
      scan_step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.out_free) begin
               if (stat.is_clear) begin
                  ctl.do_clear = 1'b1;
                  ctl.emit     = 1'b1;
                  state_in     = ST_IDLE;
               end else if (stat.is_bitop && stat.in_range) begin
                  ctl.do_bit = 1'b1;
                  if (stat.mark_walk) begin
                     ctl.ptr_inc = 1'b1;
                     state_in    = ST_SCAN;
                  end else begin
                     ctl.emit = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else if (stat.is_find) begin
                  scan_step = 1'b1;
               end else begin
                  ctl.ign  = 1'b1;
                  ctl.emit = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SCAN: begin
            scan_step = stat.out_free;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // one word per step: find walks to a free word, mark walks past full words
      if (scan_step) begin
         if (stat.is_find) begin
            if (!stat.ptr_lt_nw) begin
               ctl.hint_nw = 1'b1;
               ctl.emit    = 1'b1;
               state_in    = ST_IDLE;
            end else if (stat.word_hit) begin
               ctl.hint_ptr = 1'b1;
               ctl.fnd      = 1'b1;
               ctl.emit     = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ctl.ptr_inc = 1'b1;
               state_in    = ST_SCAN;
            end
         end else if (stat.ptr_lt_nw && stat.word_full) begin
            ctl.ptr_inc = 1'b1;
            state_in    = ST_SCAN;
         end else begin
            ctl.hint_ptr = 1'b1;
            ctl.emit     = 1'b1;
            state_in     = ST_IDLE;
         end
      end
   end

endmodule

>>> rtl/core/bma_dpath.sv
// Bitmap word memory, count, hint, limit register and result register.
module bma_dpath (
   input  logic                         clock,
   input  logic                         reset,
   input  bma_pkg::bma_req_type         req_data,
   input  logic                         csr_valid,
   input  logic [bma_pkg::COUNT_W-1:0]  csr_data,
   input  bma_pkg::bma_ctl_type         ctl,
   output bma_pkg::bma_stat_type        stat,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bma_pkg::bma_rsp_type         rsp_data
);
   import bma_pkg::*;

   logic [WORD_BITS-1:0] words_ff [MAP_WORDS];
   logic [MAP_WORDS-1:0] vld_ff, vld_in;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_vld_ff;

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [PTR_W-1:0]     ptr_ff, ptr_in;
   logic [PTR_W-1:0]     hint_ff, hint_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic [COUNT_W-1:0]   bit_count_ff, bit_count_in;
   bma_rsp_type          rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0]    eff_bits;
   logic [COUNT_W:0]      round_sum;
   logic [PTR_W-1:0]      nw, nw_m1;
   logic [WORD_SHIFT-1:0] last_pos;
   logic [WORD_BITS-1:0]  tail;
   logic [WORD_BITS-1:0]  word, find_word, mask, new_word;
   logic                  bit_set, bit_val;
   logic [WORD_SHIFT-1:0] zero_pos;
   logic [COUNT_W-1:0]    count_up, count_dn;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [WORD_BITS-1:0]  wr_data;

   // lowest clear bit: per-group search, then lowest group with a clear bit
   function automatic logic [WORD_SHIFT-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
      logic [7:0] grp_has;
      logic [2:0] grp_pos [8];
      logic [2:0] sel;
      grp_has = '0;
      sel     = '0;
      for (int g = 0; g < 8; g++) begin
         grp_has[g] = ~&w[g*8 +: 8];
         grp_pos[g] = '0;
         for (int k = 7; k >= 0; k--) begin
            if (!w[g*8+k]) grp_pos[g] = 3'(k);
         end
      end
      for (int g = 7; g >= 0; g--) begin
         if (grp_has[g]) sel = 3'(g);
      end
      return {sel, grp_pos[sel]};
   endfunction

   always_comb begin
      eff_bits  = (bit_count_ff > BITS_MAX) ? BITS_MAX : bit_count_ff;
      round_sum = {1'b0, eff_bits} + (COUNT_W+1)'(WORD_BITS - 1);
      nw        = PTR_W'(round_sum >> WORD_SHIFT);
      nw_m1     = nw - PTR_W'(1);
      last_pos  = eff_bits[WORD_SHIFT-1:0];
      tail      = (last_pos == '0) ? '0 : (FULL_WORD << last_pos);

      word      = rd_vld_ff ? rd_data_ff : '0;
      mask      = {{(WORD_BITS-1){1'b0}}, 1'b1} << idx_ff[WORD_SHIFT-1:0];
      bit_set   = |(word & mask);
      find_word = (ptr_ff == nw_m1) ? (word | tail) : word;
      zero_pos  = lowest_zero(find_word);

      case (cmd_ff)
         CMD_MARK:   new_word = word | mask;
         CMD_UNMARK: new_word = word & ~mask;
         CMD_FLIP:   new_word = word ^ mask;
         default:    new_word = word;
      endcase
      bit_val = ((cmd_ff == CMD_FLIP) && !bit_set) || ((cmd_ff == CMD_CHECK) && bit_set);

      stat.out_free  = !rsp_valid_ff || !rsp_stall;
      stat.is_clear  = (cmd_ff == CMD_CLEAR);
      stat.is_bitop  = (cmd_ff == CMD_MARK) || (cmd_ff == CMD_UNMARK) ||
                       (cmd_ff == CMD_FLIP) || (cmd_ff == CMD_CHECK);
      stat.is_find   = (cmd_ff == CMD_FIND);
      stat.in_range  = {1'b0, idx_ff} < eff_bits;
      stat.mark_walk = (cmd_ff == CMD_MARK) && !bit_set &&
                       ((word | mask) == FULL_WORD) && (ptr_ff == hint_ff);
      stat.ptr_lt_nw = ptr_ff < nw;
      stat.word_hit  = find_word != FULL_WORD;
      stat.word_full = word == FULL_WORD;
   end

   // request capture and word pointer
   always_comb begin
      cmd_in = cmd_ff;
      idx_in = idx_ff;
      ptr_in = ptr_ff;
      if (ctl.accept) begin
         cmd_in = req_data.cmd;
         idx_in = req_data.bit_sel;
         ptr_in = (req_data.cmd == CMD_FIND) ? hint_ff :
                  {1'b0, req_data.bit_sel[INDEX_W-1:WORD_SHIFT]};
      end else if (ctl.ptr_inc) begin
         ptr_in = ptr_ff + PTR_W'(1);
      end
   end

   // count and hint
   always_comb begin
      count_up = (count_ff == COUNT_LIMIT) ? count_ff : count_ff + COUNT_W'(1);
      count_dn = (count_ff == '0) ? count_ff : count_ff - COUNT_W'(1);
      count_in = count_ff;
      hint_in  = hint_ff;
      if (ctl.do_clear) begin
         count_in = '0;
         hint_in  = '0;
      end else if (ctl.do_bit) begin
         case (cmd_ff)
            CMD_MARK: begin
               if (!bit_set) count_in = count_up;
            end
            CMD_UNMARK: begin
               if (bit_set) begin
                  count_in = count_dn;
                  if (ptr_ff < hint_ff) hint_in = ptr_ff;
               end
            end
            CMD_FLIP: begin
               count_in = bit_set ? count_dn : count_up;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
      if (ctl.hint_ptr) begin
         hint_in = ptr_ff;
      end else if (ctl.hint_nw) begin
         hint_in = nw;
      end
   end

   // memory write port and valid bits
   always_comb begin
      vld_in  = vld_ff;
      wr_en   = 1'b0;
      wr_addr = ptr_ff[ADDR_W-1:0];
      wr_data = new_word;
      if (ctl.do_clear) begin
         for (int i = 0; i < MAP_WORDS; i++) begin
            if (PTR_W'(i) < nw) vld_in[i] = 1'b0;
         end
         if (nw != '0) begin
            vld_in[nw_m1[ADDR_W-1:0]] = 1'b1;
            wr_en   = 1'b1;
            wr_addr = nw_m1[ADDR_W-1:0];
            wr_data = tail;
         end
      end else if (ctl.do_bit && (cmd_ff != CMD_CHECK)) begin
         vld_in[ptr_ff[ADDR_W-1:0]] = 1'b1;
         wr_en = 1'b1;
      end
   end

   always_comb begin
      bit_count_in = csr_valid ? csr_data : bit_count_ff;
      rsp_in       = rsp_ff;
      if (ctl.emit) begin
         rsp_in.bit_state    = ctl.do_bit && bit_val;
         rsp_in.found        = ctl.fnd;
         rsp_in.found_index  = ctl.fnd ? {ptr_ff[ADDR_W-1:0], zero_pos} : '0;
         rsp_in.marked_count = count_in;
         rsp_in.all_marked   = (count_in == eff_bits);
         rsp_in.all_unmarked = (count_in == '0);
         rsp_in.ignored      = ctl.ign;
      end
      rsp_valid_in = ctl.emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         words_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= words_ff[ptr_in[ADDR_W-1:0]];
      rd_vld_ff  <= vld_in[ptr_in[ADDR_W-1:0]] & vld_ff[ptr_in[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      idx_ff <= idx_in;
      ptr_ff <= ptr_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         count_ff     <= '0;
         hint_ff      <= '0;
         bit_count_ff <= BITS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         count_ff     <= count_in;
         hint_ff      <= hint_in;
         bit_count_ff <= bit_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/bitmap_allocator_with_free_hint_core.sv
// Top level of the bitmap allocator core with free-word hint.
//
//   port group | dir | handshake             | contents
//   req_*      | in  | req_valid / req_stall | bma_req_type: cmd, bit_sel
//   rsp_*      | out | rsp_valid / rsp_stall | bma_rsp_type: result of one request
//   csr_*      | in  | csr_valid / csr_ready | bit_count limit, 13 bits
//
// Clear, mark, unmark, flip, check and out-of-range requests are accepted and
// then finish in one execute step (mark, unmark and flip read-modify-write one
// bitmap word on the single write port). Find walks from the hint word past full
// words; a mark that fills the hint word walks on past the following full words.
// Reset is synchronous; per-word valid bits give the all-zero bitmap at once.
// Every step after accept holds while a stalled result sits in the output register.
`include "assert_macros.svh"

module bitmap_allocator_with_free_hint_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  bma_pkg::bma_req_type        req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output bma_pkg::bma_rsp_type        rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bma_pkg::COUNT_W-1:0] csr_data
);
   import bma_pkg::*;

   bma_ctl_type  ctl;
   bma_stat_type stat;

   assign csr_ready = 1'b1;

   bma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   bma_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .ctl       (ctl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `ASSERT_NEXT(a_one_in_flight, clock, reset, ctl.accept, !ctl.accept && req_stall)
   `ASSERT_IMPLIES(a_emit_when_free, clock, reset, ctl.emit, !rsp_valid || !rsp_stall)
   `ASSERT_NEXT(a_emit_shows, clock, reset, ctl.emit, rsp_valid)
   `ASSERT_IMPLIES(a_no_find_no_index, clock, reset, rsp_valid && !rsp_data.found, rsp_data.found_index == '0)

endmodule
